>>> sv/ssq_pkg.sv
// Package for the stepper segment queue: command codes, segment record, FSM states.
// No dependencies.
package ssq_pkg;

  localparam int QueueDepth = 64;
  localparam int IdxW = $clog2(QueueDepth);
  localparam logic [31:0] PhasePerStep = 32'd1048576;

  typedef enum logic [2:0] {
    CMD_TICK = 3'd0,
    CMD_PUSH = 3'd1,
    CMD_SYNC = 3'd2,
    CMD_VEL  = 3'd3,
    CMD_ENA  = 3'd4,
    CMD_DIS  = 3'd5
  } cmd_t;

  typedef struct packed {
    logic [7:0] key;
    logic [7:0] major;
    logic       dir;
    logic [7:0] axis;
    logic [7:0] accel;
    logic [7:0] up;
    logic [7:0] down;
    logic [7:0] hold;
  } seg_t;

  localparam int SegW = $bits(seg_t);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_EXEC,
    ST_SCAN,
    ST_CLEAR,
    ST_OUT
  } state_t;

endpackage

>>> sv/ssq_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module ssq_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> sv/stepper_segment_queue_generator.sv
// Top level of the stepper segment queue: sequencer, step generator and segment store.
// Depends on ssq_pkg and ssq_ram.
//
// Segments sit in a 64-entry ring RAM; every request gives one response. After reset a
// clearing pass zeroes the RAM before the first request is taken. A request passes
// through RAM read, execute and response states; a sync also walks the ring one entry per
// cycle between execute and response. The input side is ready again the cycle after the
// response is taken, so a new request is not accepted until the last response is taken.
module stepper_segment_queue_generator (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] in_cmd,
  input  logic [7:0] in_seg_major_steps,
  input  logic       in_seg_direction,
  input  logic [7:0] in_seg_axis_steps,
  input  logic [7:0] in_seg_accel,
  input  logic [7:0] in_seg_accel_steps,
  input  logic [7:0] in_seg_decel_steps,
  input  logic [7:0] in_seg_hold,
  input  logic [15:0] in_velocity_word,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_step_pulse,
  output logic       out_direction_out,
  output logic       out_driver_on,
  output logic       out_status_ok,
  output logic [7:0] out_current_key,
  output logic [7:0] out_steps_left,
  output logic [5:0] out_read_slot,
  output logic [5:0] out_write_slot,
  output logic       out_waiting_sync,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_data
);
  localparam int W = ssq_pkg::IdxW;

  ssq_pkg::state_t st_r, st_nxt;
  logic [2:0]  cmd_r;
  ssq_pkg::seg_t in_seg_r;
  logic [15:0] vel_r;
  logic [2:0]  sh_r;
  logic [W-1:0] rd_r, wr_r, sy_r, scan_r, clr_r;
  logic [6:0]  scan_n_r;
  logic [7:0]  key_r;
  logic [15:0] mtot_r, mleft_r, thr_r, ainc_r, aerr_r, up_r, dn_r, acc_r;
  logic [31:0] speed_r, phase_r;
  logic        wait_r, lock_r, dir_r, ena_r;
  logic [7:0]  cur_key_r;

  // RAM port control
  logic         we;
  logic [W-1:0] waddr, raddr;
  ssq_pkg::seg_t wdata, rseg;
  logic [ssq_pkg::SegW-1:0] rdata;

  assign rseg = ssq_pkg::seg_t'(rdata);

  ssq_ram #(.Width(ssq_pkg::SegW), .Depth(ssq_pkg::QueueDepth)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  function automatic logic [W-1:0] nxt_slot(input logic [W-1:0] i);
    nxt_slot = (i == W'(ssq_pkg::QueueDepth - 1)) ? '0 : i + W'(1);
  endfunction

  logic [W-1:0] rd_nx, wr_nx, scan_nx;
  assign rd_nx   = nxt_slot(rd_r);
  assign wr_nx   = nxt_slot(wr_r);
  assign scan_nx = nxt_slot(scan_r);

  assign in_ready  = (st_r == ssq_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;

  // Next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ssq_pkg::ST_CLEAR: if (clr_r == W'(ssq_pkg::QueueDepth - 1)) st_nxt = ssq_pkg::ST_IDLE;
      ssq_pkg::ST_IDLE:  if (in_valid) st_nxt = ssq_pkg::ST_RD;
      ssq_pkg::ST_RD:    st_nxt = ssq_pkg::ST_EXEC;
      ssq_pkg::ST_EXEC: begin
        if (cmd_r == ssq_pkg::CMD_SYNC && sy_r != wr_r) st_nxt = ssq_pkg::ST_SCAN;
        else st_nxt = ssq_pkg::ST_OUT;
      end
      ssq_pkg::ST_SCAN: begin
        if (rseg.hold == 8'd1 || scan_r == wr_r || scan_n_r == 7'(ssq_pkg::QueueDepth))
          st_nxt = ssq_pkg::ST_OUT;
      end
      ssq_pkg::ST_OUT:   if (out_ready) st_nxt = ssq_pkg::ST_IDLE;
      default:           st_nxt = ssq_pkg::ST_IDLE;
    endcase
  end

  // RAM addressing: the read address in ST_RD prefetches the entry EXEC needs.
  always_comb begin
    we    = 1'b0;
    waddr = wr_nx;
    wdata = in_seg_r;
    raddr = rd_nx;
    wdata.key = key_r + 8'd1;
    priority case (st_r)
      ssq_pkg::ST_CLEAR: begin
        we = 1'b1;
        waddr = clr_r;
        wdata = '0;
      end
      ssq_pkg::ST_RD: raddr = (cmd_r == ssq_pkg::CMD_SYNC) ? nxt_slot(sy_r) : rd_nx;
      ssq_pkg::ST_EXEC: begin
        we = (cmd_r == ssq_pkg::CMD_PUSH) && (wr_nx != rd_r);
        raddr = nxt_slot(sy_r);
      end
      ssq_pkg::ST_SCAN: begin
        raddr = scan_nx;
        if (rseg.hold == 8'd1) begin
          we = 1'b1;
          waddr = scan_r;
          wdata = rseg;
          wdata.hold = 8'd0;
        end
      end
      default: raddr = rd_r;
    endcase
  end

  // Tick arithmetic
  logic [15:0] done;
  logic [31:0] spd_t, ph_sum;
  logic        lock_t;
  logic [15:0] aerr_sum;
  always_comb begin
    done   = mtot_r - mleft_r;
    spd_t  = speed_r;
    lock_t = lock_r;
    if (up_r > done) spd_t = speed_r + {16'd0, acc_r};
    else if (dn_r >= mleft_r) begin
      if (speed_r > {16'd0, acc_r}) spd_t = speed_r - {16'd0, acc_r};
      else lock_t = 1'b1;
    end
    ph_sum   = phase_r + spd_t;
    aerr_sum = aerr_r + ainc_r;
  end

  logic [15:0] ld_major;
  assign ld_major = 16'({8'd0, rseg.major} << sh_r);

  logic pulse_r, ok_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ssq_pkg::ST_CLEAR;
      clr_r <= '0;
      sh_r <= 3'd2;
      rd_r <= '0; wr_r <= '0; sy_r <= '0;
      key_r <= 8'd255;
      mtot_r <= '0; mleft_r <= '0; thr_r <= '0; ainc_r <= '0; aerr_r <= '0;
      up_r <= '0; dn_r <= '0; acc_r <= '0; speed_r <= '0; phase_r <= '0;
      wait_r <= 1'b0; lock_r <= 1'b0; dir_r <= 1'b0; ena_r <= 1'b0;
      pulse_r <= 1'b0; ok_r <= 1'b1; cur_key_r <= '0;
      scan_r <= '0; scan_n_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (cfg_valid && cfg_ready) sh_r <= cfg_data;
      if (st_r == ssq_pkg::ST_CLEAR) clr_r <= clr_r + W'(1);
      if (st_r == ssq_pkg::ST_IDLE && in_valid) begin
        cmd_r <= in_cmd;
        in_seg_r <= '{key: 8'd0, major: in_seg_major_steps, dir: in_seg_direction,
                      axis: in_seg_axis_steps, accel: in_seg_accel,
                      up: in_seg_accel_steps, down: in_seg_decel_steps,
                      hold: in_seg_hold};
        vel_r <= in_velocity_word;
      end
      if (st_r == ssq_pkg::ST_EXEC) begin
        pulse_r <= 1'b0;
        ok_r <= 1'b1;
        unique case (cmd_r)
          ssq_pkg::CMD_TICK: begin
            if (mleft_r != 16'd0) begin
              speed_r <= spd_t;
              lock_r <= lock_t;
              if (ph_sum > ssq_pkg::PhasePerStep) begin
                mleft_r <= mleft_r - 16'd1;
                phase_r <= ph_sum - ssq_pkg::PhasePerStep;
                if ($signed(aerr_sum) > $signed(thr_r)) begin
                  pulse_r <= 1'b1;
                  aerr_r <= aerr_sum - mtot_r;
                end else aerr_r <= aerr_sum;
              end else phase_r <= ph_sum;
            end else if (wr_r != rd_r) begin
              if (lock_r) begin
                speed_r <= '0;
                lock_r <= 1'b0;
              end
              if (rseg.hold != 8'd0) wait_r <= 1'b1;
              else begin
                wait_r <= 1'b0;
                ena_r <= 1'b1;
                if (sy_r == rd_r) sy_r <= nxt_slot(sy_r);
                rd_r <= rd_nx;
                cur_key_r <= rseg.key;
                mtot_r <= ld_major;
                mleft_r <= ld_major;
                thr_r <= ld_major >> 1;
                dir_r <= rseg.dir;
                ainc_r <= 16'({8'd0, rseg.axis} << sh_r);
                aerr_r <= '0;
                up_r <= 16'({8'd0, rseg.up} << sh_r);
                dn_r <= 16'({8'd0, rseg.down} << sh_r);
                acc_r <= 16'({8'd0, rseg.accel} << sh_r);
                phase_r <= '0;
              end
            end
          end
          ssq_pkg::CMD_PUSH: begin
            if (wr_nx != rd_r) begin
              key_r <= key_r + 8'd1;
              wr_r <= wr_nx;
            end else ok_r <= 1'b0;
          end
          ssq_pkg::CMD_SYNC: begin
            scan_r <= nxt_slot(sy_r);
            scan_n_r <= 7'd1;
            if (sy_r == wr_r) sy_r <= sy_r;
          end
          ssq_pkg::CMD_VEL: speed_r <= 32'({16'd0, vel_r} << (5'd4 + 5'(sh_r)));
          ssq_pkg::CMD_ENA: ena_r <= 1'b1;
          ssq_pkg::CMD_DIS: ena_r <= 1'b0;
          default: ;
        endcase
      end
      if (st_r == ssq_pkg::ST_SCAN) begin
        // scan_r holds pos after the step; rseg is that entry.
        if (rseg.hold == 8'd1) sy_r <= scan_r;
        else if (scan_r == wr_r || scan_n_r == 7'(ssq_pkg::QueueDepth)) sy_r <= scan_r;
        scan_r <= scan_nx;
        scan_n_r <= scan_n_r + 7'd1;
      end
    end
  end

  assign out_valid         = (st_r == ssq_pkg::ST_OUT);
  assign out_step_pulse    = pulse_r;
  assign out_direction_out = dir_r;
  assign out_driver_on     = ena_r;
  assign out_status_ok     = ok_r;
  assign out_current_key   = cur_key_r;
  assign out_steps_left    = 8'(mleft_r >> sh_r);
  assign out_read_slot     = 6'(rd_r);
  assign out_write_slot    = 6'(wr_r);
  assign out_waiting_sync  = wait_r;

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != ssq_pkg::ST_IDLE) |-> !in_ready) else $error("accepted while busy");
  a_out_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> ($past(st_r) == ssq_pkg::ST_EXEC || $past(st_r) == ssq_pkg::ST_SCAN))
    else $error("response without execution");
  a_ring_not_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ssq_pkg::ST_EXEC && cmd_r == ssq_pkg::CMD_PUSH && wr_nx == rd_r) |=> !ok_r)
    else $error("full ring accepted a push");
endmodule

>>> dv/stepper_segment_queue_generator_tb.sv
// Self-checking testbench for the stepper segment queue generator.
// Depends on ssq_pkg and the stepper_segment_queue_generator RTL.
module stepper_segment_queue_generator_tb;

  typedef struct packed {
    logic       pulse;
    logic       dir;
    logic       drv;
    logic       ok;
    logic [7:0] key;
    logic [7:0] left;
    logic [5:0] rd;
    logic [5:0] wr;
    logic       wait_s;
  } status_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] in_cmd = '0;
  logic [7:0] in_seg_major_steps = '0;
  logic in_seg_direction = 1'b0;
  logic [7:0] in_seg_axis_steps = '0;
  logic [7:0] in_seg_accel = '0;
  logic [7:0] in_seg_accel_steps = '0;
  logic [7:0] in_seg_decel_steps = '0;
  logic [7:0] in_seg_hold = '0;
  logic [15:0] in_velocity_word = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_step_pulse, out_direction_out, out_driver_on, out_status_ok, out_waiting_sync;
  logic [7:0] out_current_key, out_steps_left;
  logic [5:0] out_read_slot, out_write_slot;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_data = '0;

  stepper_segment_queue_generator uut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow state of the block.
  ssq_pkg::seg_t ring [ssq_pkg::QueueDepth];
  int      rd_i, wr_i, sy_i;
  logic [7:0]  key_ctr;
  logic [15:0] maj_total, maj_left, err_thr, ax_inc, ax_err, up_s, down_s, acc_amt;
  logic [31:0] spd, ph;
  logic    f_wait, f_lock, f_dir, f_ena;
  logic [2:0] ushift;

  status_t expected_status[$];
  int      errors = 0;
  int      sent = 0;
  int      checked = 0;
  int      send_idle = 0;
  int      recv_idle = 0;
  int      hold_off = 0;

  function automatic int nslot(int i);
    return (i + 1 >= ssq_pkg::QueueDepth) ? 0 : i + 1;
  endfunction

  function automatic logic [15:0] shl16(logic [7:0] v);
    logic [31:0] w;
    w = {24'd0, v} << ushift;
    return w[15:0];
  endfunction

  task automatic load_segment();
    int nx;
    if (wr_i == rd_i) return;
    if (f_lock) begin
      spd = '0;
      f_lock = 1'b0;
    end
    nx = nslot(rd_i);
    if (ring[nx].hold != 0) begin
      f_wait = 1'b1;
      return;
    end
    f_wait = 1'b0;
    f_ena = 1'b1;
    if (sy_i == rd_i) sy_i = nslot(sy_i);
    rd_i = nx;
    maj_total = shl16(ring[nx].major);
    err_thr = maj_total >> 1;
    maj_left = maj_total;
    f_dir = ring[nx].dir;
    ax_inc = shl16(ring[nx].axis);
    ax_err = '0;
    up_s = shl16(ring[nx].up);
    down_s = shl16(ring[nx].down);
    acc_amt = shl16(ring[nx].accel);
    ph = '0;
  endtask

  task automatic step_motion(output logic pulse);
    logic [15:0] done;
    pulse = 1'b0;
    if (maj_left == 0) begin
      load_segment();
      return;
    end
    done = maj_total - maj_left;
    if (up_s > done) spd = spd + {16'd0, acc_amt};
    else if (down_s >= maj_left) begin
      if (spd > {16'd0, acc_amt}) spd = spd - {16'd0, acc_amt};
      else f_lock = 1'b1;
    end
    ph = ph + spd;
    if (ph > ssq_pkg::PhasePerStep) begin
      maj_left = maj_left - 1'b1;
      ph = ph - ssq_pkg::PhasePerStep;
      ax_err = ax_err + ax_inc;
      if ($signed(ax_err) > $signed(err_thr)) begin
        pulse = 1'b1;
        ax_err = ax_err - maj_total;
      end
    end
  endtask

  task automatic release_sync();
    int pos;
    pos = sy_i;
    for (int n = 0; n <= ssq_pkg::QueueDepth; n++) begin
      if (pos == wr_i) begin
        sy_i = pos;
        return;
      end
      pos = nslot(pos);
      if (ring[pos].hold == 8'd1) begin
        sy_i = pos;
        ring[pos].hold = 8'd0;
        return;
      end
    end
    sy_i = pos;
  endtask

  task automatic predict_status(input logic [2:0] cmd, input ssq_pkg::seg_t sg,
                                input logic [15:0] vel);
    status_t r;
    logic pulse;
    logic [15:0] lft;
    logic ok;
    int nx;
    pulse = 1'b0;
    ok = 1'b1;
    case (cmd)
      ssq_pkg::CMD_TICK: step_motion(pulse);
      ssq_pkg::CMD_PUSH: begin
        nx = nslot(wr_i);
        if (nx == rd_i) ok = 1'b0;
        else begin
          key_ctr = key_ctr + 1'b1;
          ring[nx] = sg;
          ring[nx].key = key_ctr;
          wr_i = nx;
        end
      end
      ssq_pkg::CMD_SYNC: release_sync();
      ssq_pkg::CMD_VEL: spd = {16'd0, vel} << (4 + ushift);
      ssq_pkg::CMD_ENA: f_ena = 1'b1;
      ssq_pkg::CMD_DIS: f_ena = 1'b0;
      default: ;
    endcase
    lft = maj_left >> ushift;
    r = '{pulse, f_dir, f_ena, ok, ring[rd_i].key, lft[7:0], rd_i[5:0], wr_i[5:0], f_wait};
    expected_status.push_back(r);
  endtask

  // Valid drops only while the sender idles or drains, so a back-to-back
  // request never sees two assignments to it in one step.
  task automatic send_request(input logic [2:0] cmd, input ssq_pkg::seg_t sg,
                              input logic [15:0] vel);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    predict_status(cmd, sg, vel);
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_seg_major_steps <= sg.major;
    in_seg_direction <= sg.dir;
    in_seg_axis_steps <= sg.axis;
    in_seg_accel <= sg.accel;
    in_seg_accel_steps <= sg.up;
    in_seg_decel_steps <= sg.down;
    in_seg_hold <= sg.hold;
    in_velocity_word <= vel;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  function automatic ssq_pkg::seg_t rand_seg(input int maxmaj, input int holdsel);
    ssq_pkg::seg_t s;
    s.key = '0;
    s.major = 8'($urandom_range(maxmaj));
    s.dir = 1'($urandom_range(1));
    s.axis = 8'($urandom_range(255));
    s.accel = 8'($urandom_range(255));
    s.up = 8'($urandom_range(255));
    s.down = 8'($urandom_range(255));
    s.hold = (holdsel == 0) ? 8'd0 : (holdsel == 1) ? 8'd1 : 8'($urandom_range(2, 255));
    return s;
  endfunction

  task automatic send_cmd(input logic [2:0] cmd);
    send_request(cmd, rand_seg(255, $urandom_range(2)), 16'($urandom));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_status.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_shift(input logic [2:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    ushift = v;
  endtask

  // Result checker.
  always @(posedge clk) begin
    status_t got, exp_s;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_step_pulse, out_direction_out, out_driver_on, out_status_ok,
              out_current_key, out_steps_left, out_read_slot, out_write_slot,
              out_waiting_sync};
      if (expected_status.size() == 0) begin
        $error("unexpected result");
        errors++;
      end else begin
        exp_s = expected_status.pop_front();
        checked++;
        if (got.pulse !== exp_s.pulse) begin
          $error("step_pulse exp %0d got %0d", exp_s.pulse, got.pulse); errors++; end
        if (got.dir !== exp_s.dir) begin
          $error("direction_out exp %0d got %0d", exp_s.dir, got.dir); errors++; end
        if (got.drv !== exp_s.drv) begin
          $error("driver_on exp %0d got %0d", exp_s.drv, got.drv); errors++; end
        if (got.ok !== exp_s.ok) begin
          $error("status_ok exp %0d got %0d", exp_s.ok, got.ok); errors++; end
        if (got.key !== exp_s.key) begin
          $error("current_key exp %0d got %0d", exp_s.key, got.key); errors++; end
        if (got.left !== exp_s.left) begin
          $error("steps_left exp %0d got %0d", exp_s.left, got.left); errors++; end
        if (got.rd !== exp_s.rd) begin
          $error("read_slot exp %0d got %0d", exp_s.rd, got.rd); errors++; end
        if (got.wr !== exp_s.wr) begin
          $error("write_slot exp %0d got %0d", exp_s.wr, got.wr); errors++; end
        if (got.wait_s !== exp_s.wait_s) begin
          $error("waiting_sync exp %0d got %0d", exp_s.wait_s, got.wait_s); errors++; end
      end
    end
  end

  // Receiver ready, with an optional long hold-off counted here.
  always @(posedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic test_directed();
    ssq_pkg::seg_t s;
    send_cmd(3'd6);
    send_cmd(3'd7);
    send_request(ssq_pkg::CMD_TICK, rand_seg(0, 0), '0);
    send_cmd(ssq_pkg::CMD_ENA);
    send_cmd(ssq_pkg::CMD_DIS);
    s = '{8'd0, 8'd255, 1'b1, 8'd255, 8'd255, 8'd255, 8'd255, 8'd0};
    send_request(ssq_pkg::CMD_PUSH, s, '0);
    s = '{8'd0, 8'd0, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd1};
    send_request(ssq_pkg::CMD_PUSH, s, '0);
    s.hold = 8'd255;
    send_request(ssq_pkg::CMD_PUSH, s, '0);
    send_request(ssq_pkg::CMD_VEL, s, 16'hFFFF);
    repeat (4) send_request(ssq_pkg::CMD_TICK, s, '0);
    send_cmd(ssq_pkg::CMD_SYNC);
    send_cmd(ssq_pkg::CMD_SYNC);
    send_request(ssq_pkg::CMD_VEL, s, 16'h0000);
    repeat (4) send_request(ssq_pkg::CMD_TICK, s, '0);
  endtask

  // Fill the ring to overflow, with the receiver holding off at the start.
  task automatic test_full_ring();
    hold_off = 300;
    repeat (ssq_pkg::QueueDepth + 2)
      send_request(ssq_pkg::CMD_PUSH, rand_seg(3, 0), 16'($urandom));
    drain();
  endtask

  // Mostly short moves driven by ticks, mixed with syncs, velocity and enable commands and undefined codes.
  task automatic test_random(input int n);
    int k;
    for (k = 0; k < n; k++) begin
      case ($urandom_range(19))
        0, 1, 2: send_request(ssq_pkg::CMD_PUSH, rand_seg(6, ($urandom_range(9) == 0) ?
                              $urandom_range(1, 2) : 0), '0);
        3: send_cmd(ssq_pkg::CMD_SYNC);
        4: send_request(ssq_pkg::CMD_VEL, rand_seg(0, 0), 16'($urandom));
        5: send_cmd($urandom_range(3) == 0 ? ssq_pkg::CMD_DIS : ssq_pkg::CMD_ENA);
        6: send_cmd(3'($urandom_range(6, 7)));
        7: send_cmd(3'($urandom));
        default: send_request(ssq_pkg::CMD_TICK, rand_seg(0, 0), '0);
      endcase
    end
  endtask

  initial begin
    logic [2:0] shifts[5];
    for (int i = 0; i < ssq_pkg::QueueDepth; i++) ring[i] = '0;
    rd_i = 0; wr_i = 0; sy_i = 0;
    key_ctr = 8'd255;
    {maj_total, maj_left, err_thr, ax_inc, ax_err, up_s, down_s, acc_amt} = '0;
    spd = '0; ph = '0;
    {f_wait, f_lock, f_dir, f_ena} = '0;
    ushift = 3'd2;
    shifts = '{3'd0, 3'd4, 3'd7, 3'd1, 3'd2};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle = 26; recv_idle = 65;
    test_directed();
    test_full_ring();
    for (int p = 0; p < 5; p++) begin
      write_shift(shifts[p]);
      if (p == 2) begin send_idle = 65; recv_idle = 26; end
      if (p == 4) begin send_idle = 0; recv_idle = 0; end
      test_random(180);
      // Sender pauses here until every result is back.
      drain();
    end
    drain();
    $display("Sent %0d requests over five microstep settings, %0d responses checked.",
             sent, checked);
    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

>>> sim.f
sv/ssq_pkg.sv
sv/ssq_ram.sv
sv/stepper_segment_queue_generator.sv
dv/stepper_segment_queue_generator_tb.sv
